@@ design/qrm_pkg.sv @@
// Package with the payload types, sizes and pipeline stage types of the rotation matrix block.
package qrm_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned FRAC_B = 14;
  localparam int unsigned N_W    = 2 * WORD_W + 1;
  localparam int unsigned Q_W    = FRAC_B + 2;
  localparam int unsigned LANES  = 9;

  localparam logic signed [WORD_W-1:0] SMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] SMIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [WORD_W-1:0] quat_x;
    logic signed [WORD_W-1:0] quat_y;
    logic signed [WORD_W-1:0] quat_z;
    logic signed [WORD_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] r00;
    logic signed [WORD_W-1:0] r01;
    logic signed [WORD_W-1:0] r02;
    logic signed [WORD_W-1:0] r10;
    logic signed [WORD_W-1:0] r11;
    logic signed [WORD_W-1:0] r12;
    logic signed [WORD_W-1:0] r20;
    logic signed [WORD_W-1:0] r21;
    logic signed [WORD_W-1:0] r22;
    logic                     degenerate;
  } result_t;

  typedef struct packed {
    logic           neg;
    logic [N_W-1:0] rem;
    logic [Q_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  degen;
    logic [N_W-1:0]        norm;
    lane_t [LANES-1:0]     lane;
  } stage_t;

endpackage

@@ design/qrm_front.sv @@
// Front end: halving of all-even inputs, products, numerators and norm, and the first quotient bit.
module qrm_front import qrm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  quat_t  quat_i,
  output stage_t stage_o
);

  localparam int unsigned P_W = 2 * WORD_W;

  logic signed [WORD_W-1:0] x, y, z, w;
  logic signed [P_W-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic v1_q, v2_q, v3_q;
  logic [N_W-1:0] mag_d [LANES];
  logic           neg_d [LANES];
  logic [N_W-1:0] mag_q [LANES];
  logic           neg_q [LANES];
  logic [N_W-1:0] norm_d, norm_q;
  stage_t stage_d, stage_q;

  always_comb begin
    if (!(quat_i.quat_x[0] | quat_i.quat_y[0] | quat_i.quat_z[0] | quat_i.quat_w[0])) begin
      x = quat_i.quat_x >>> 1;
      y = quat_i.quat_y >>> 1;
      z = quat_i.quat_z >>> 1;
      w = quat_i.quat_w >>> 1;
    end else begin
      x = quat_i.quat_x;
      y = quat_i.quat_y;
      z = quat_i.quat_z;
      w = quat_i.quat_w;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= x * x;
    yy_q <= y * y;
    zz_q <= z * z;
    ww_q <= w * w;
    xy_q <= x * y;
    wz_q <= w * z;
    xz_q <= x * z;
    wy_q <= w * y;
    yz_q <= y * z;
    wx_q <= w * x;
  end

  function automatic logic [N_W:0] diag_f(logic signed [P_W-1:0] a, logic signed [P_W-1:0] b,
                                          logic signed [P_W-1:0] c, logic signed [P_W-1:0] d);
    logic [N_W-1:0] p, m;
    p = N_W'(unsigned'(a)) + N_W'(unsigned'(b));
    m = N_W'(unsigned'(c)) + N_W'(unsigned'(d));
    if (p >= m) diag_f = {1'b0, p - m};
    else diag_f = {1'b1, m - p};
  endfunction

  function automatic logic [N_W:0] offd_f(logic signed [P_W-1:0] a, logic signed [P_W-1:0] b,
                                          logic sub);
    logic signed [N_W-1:0] s;
    logic [N_W-1:0] mag;
    s = sub ? (N_W'(a) - N_W'(b)) : (N_W'(a) + N_W'(b));
    mag = s[N_W-1] ? N_W'(-s) : N_W'(s);
    offd_f = {s[N_W-1], mag[N_W-2:0], 1'b0};
  endfunction

  always_comb begin
    logic [N_W:0] t [LANES];
    t[0] = diag_f(ww_q, xx_q, yy_q, zz_q);
    t[1] = offd_f(xy_q, wz_q, 1'b1);
    t[2] = offd_f(xz_q, wy_q, 1'b0);
    t[3] = offd_f(xy_q, wz_q, 1'b0);
    t[4] = diag_f(ww_q, yy_q, xx_q, zz_q);
    t[5] = offd_f(yz_q, wx_q, 1'b1);
    t[6] = offd_f(xz_q, wy_q, 1'b1);
    t[7] = offd_f(yz_q, wx_q, 1'b0);
    t[8] = diag_f(ww_q, zz_q, xx_q, yy_q);
    for (int i = 0; i < LANES; i++) begin
      neg_d[i] = t[i][N_W];
      mag_d[i] = t[i][N_W-1:0];
    end
    norm_d = N_W'(unsigned'(xx_q)) + N_W'(unsigned'(yy_q))
           + N_W'(unsigned'(zz_q)) + N_W'(unsigned'(ww_q));
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
    for (int i = 0; i < LANES; i++) begin
      mag_q[i] <= mag_d[i];
      neg_q[i] <= neg_d[i];
    end
  end

  always_comb begin
    stage_d.valid = v2_q;
    stage_d.degen = (norm_q == '0);
    stage_d.norm  = norm_q;
    for (int i = 0; i < LANES; i++) begin
      stage_d.lane[i].neg = neg_q[i];
      if (mag_q[i] >= norm_q) begin
        stage_d.lane[i].quo = Q_W'(1);
        stage_d.lane[i].rem = mag_q[i] - norm_q;
      end else begin
        stage_d.lane[i].quo = '0;
        stage_d.lane[i].rem = mag_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = v3_q;
  end

endmodule

@@ design/qrm_div_step.sv @@
// One restoring division step for all nine lanes, registered.
module qrm_div_step import qrm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  output stage_t stage_o
);

  stage_t stage_d, stage_q;
  logic   valid_q;

  always_comb begin
    logic [N_W:0] r2;
    stage_d = stage_i;
    for (int i = 0; i < LANES; i++) begin
      r2 = {stage_i.lane[i].rem, 1'b0};
      if (r2 >= {1'b0, stage_i.norm}) begin
        stage_d.lane[i].quo = {stage_i.lane[i].quo[Q_W-2:0], 1'b1};
        stage_d.lane[i].rem = N_W'(r2 - {1'b0, stage_i.norm});
      end else begin
        stage_d.lane[i].quo = {stage_i.lane[i].quo[Q_W-2:0], 1'b0};
        stage_d.lane[i].rem = r2[N_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ design/quat_to_rotation_matrix.sv @@
// Top level of the quaternion to 3x3 rotation matrix pipeline.
// A quaternion beat is taken at each rising edge with start_i high and busy_o low.
// busy_o is always low: the pipeline takes one beat in every cycle.
// Each beat gives one result beat on result_o, marked by done_o for one cycle,
// in order.
// The pipeline is one product stage, one sum stage,
// one stage for the integer quotient bit, 14 stages of one fraction bit each,
// and the rounding and saturation output register.
// Throughput is one beat per cycle.
// Entries are Q1.14, rounded to nearest with ties away from zero.
// An all-zero quaternion gives the identity with degenerate set.
// Reset clears all valid bits; no result appears until a new beat enters.
// The receiver cannot stall, so results are never held.
module quat_to_rotation_matrix import qrm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  quat_t   quat_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);

  localparam logic signed [Q_W:0] ONE = (Q_W+1)'(1) <<< FRAC_B;

  stage_t st [FRAC_B+1];
  logic [WORD_W-1:0] ent_d [LANES];
  result_t result_d, result_q;
  logic    done_q;

  assign busy_o = 1'b0;

  qrm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .quat_i  (quat_i),
    .stage_o (st[0])
  );

  for (genvar g = 0; g < FRAC_B; g++) begin : g_step
    qrm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (st[g]),
      .stage_o (st[g+1])
    );
  end

  always_comb begin
    logic [N_W:0] r2;
    logic [Q_W-1:0] q;
    logic signed [Q_W:0] v;
    for (int i = 0; i < LANES; i++) begin
      r2 = {st[FRAC_B].lane[i].rem, 1'b0};
      q  = st[FRAC_B].lane[i].quo + Q_W'(r2 >= {1'b0, st[FRAC_B].norm});
      v  = st[FRAC_B].lane[i].neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
      if (st[FRAC_B].degen) begin
        v = (i == 0 || i == 4 || i == 8) ? ONE : '0;
      end
      if (v > (Q_W+1)'(SMAX)) ent_d[i] = SMAX;
      else if (v < (Q_W+1)'(SMIN)) ent_d[i] = SMIN;
      else ent_d[i] = v[WORD_W-1:0];
    end
    result_d.r00 = ent_d[0];
    result_d.r01 = ent_d[1];
    result_d.r02 = ent_d[2];
    result_d.r10 = ent_d[3];
    result_d.r11 = ent_d[4];
    result_d.r12 = ent_d[5];
    result_d.r20 = ent_d[6];
    result_d.r21 = ent_d[7];
    result_d.r22 = ent_d[8];
    result_d.degenerate = st[FRAC_B].degen;
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= st[FRAC_B].valid;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_degen_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |->
      result_o.r00 == WORD_W'(ONE) && result_o.r01 == '0 && result_o.r22 == WORD_W'(ONE))
    else $error("degenerate result is not the identity");

  a_diag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.degenerate |->
      $signed(result_o.r11) <= $signed(WORD_W'(ONE)) &&
      $signed(result_o.r11) >= -$signed(WORD_W'(ONE)))
    else $error("diagonal entry beyond unit magnitude");

  a_off_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |->
      $signed(result_o.r01) <= $signed(WORD_W'(ONE)) &&
      $signed(result_o.r01) >= -$signed(WORD_W'(ONE)))
    else $error("off-diagonal entry beyond unit magnitude");

endmodule

@@ test/quat_to_rotation_matrix_tb.sv @@
// Self-checking testbench of the quaternion to rotation matrix pipeline.
`timescale 1ns / 1ps

module quat_to_rotation_matrix_tb;
  import qrm_pkg::*;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  quat_t   quat_i;
  logic    busy_o;
  logic    done_o;
  result_t result_o;

  result_t matrix_q[$];
  int      error_count;
  int      beat_count;
  int      result_count;
  int      degen_count;

  quat_to_rotation_matrix DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .quat_i  (quat_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic signed [WORD_W-1:0] scaled_ratio(input logic neg,
      input longint unsigned mag, input longint unsigned n);
    longint unsigned q;
    longint unsigned r;
    longint          v;
    if (mag >= n) begin
      q = 1;
      r = mag - n;
    end else begin
      q = 0;
      r = mag;
    end
    for (int i = 0; i < FRAC_B; i++) begin
      if (r >= n - r) begin
        q = 2 * q + 1;
        r = r - (n - r);
      end else begin
        q = 2 * q;
        r = 2 * r;
      end
    end
    if (r >= n - r) q++;
    v = neg ? -longint'(q) : longint'(q);
    if (v > longint'(SMAX)) v = SMAX;
    if (v < longint'(SMIN)) v = SMIN;
    return v[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] diag_entry(input longint unsigned p,
      input longint unsigned m, input longint unsigned n);
    if (p >= m) return scaled_ratio(1'b0, p - m, n);
    return scaled_ratio(1'b1, m - p, n);
  endfunction

  function automatic logic signed [WORD_W-1:0] cross_entry(input longint s,
      input longint unsigned n);
    longint unsigned mag;
    mag = (s < 0) ? longint'(-s) : s;
    return scaled_ratio(s < 0, 2 * mag, n);
  endfunction

  function automatic result_t rotation_of(input quat_t q);
    result_t r;
    longint x, y, z, w;
    longint unsigned xx, yy, zz, ww, n;
    x = q.quat_x;
    y = q.quat_y;
    z = q.quat_z;
    w = q.quat_w;
    if (((x | y | z | w) & 1) == 0) begin
      x = x / 2;
      y = y / 2;
      z = z / 2;
      w = w / 2;
    end
    xx = x * x;
    yy = y * y;
    zz = z * z;
    ww = w * w;
    n = xx + yy + zz + ww;
    r = '0;
    if (n == 0) begin
      r.r00 = WORD_W'(1 << FRAC_B);
      r.r11 = WORD_W'(1 << FRAC_B);
      r.r22 = WORD_W'(1 << FRAC_B);
      r.degenerate = 1'b1;
    end else begin
      r.r00 = diag_entry(ww + xx, yy + zz, n);
      r.r01 = cross_entry(x * y - w * z, n);
      r.r02 = cross_entry(x * z + w * y, n);
      r.r10 = cross_entry(x * y + w * z, n);
      r.r11 = diag_entry(ww + yy, xx + zz, n);
      r.r12 = cross_entry(y * z - w * x, n);
      r.r20 = cross_entry(x * z - w * y, n);
      r.r21 = cross_entry(y * z + w * x, n);
      r.r22 = diag_entry(ww + zz, xx + yy, n);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what,
             got, want);
    error_count++;
  endtask

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 99) < 60) n = 0;
    else if ($urandom_range(0, 99) < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_quat(input quat_t q, input bit gaps);
    if (gaps) idle_gap();
    start_i <= 1'b1;
    quat_i  <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    matrix_q.push_back(rotation_of(q));
    beat_count++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (matrix_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = matrix_q.pop_front();
        if (result_o.r00 !== want.r00) report_mismatch("r00", result_o.r00, want.r00);
        if (result_o.r01 !== want.r01) report_mismatch("r01", result_o.r01, want.r01);
        if (result_o.r02 !== want.r02) report_mismatch("r02", result_o.r02, want.r02);
        if (result_o.r10 !== want.r10) report_mismatch("r10", result_o.r10, want.r10);
        if (result_o.r11 !== want.r11) report_mismatch("r11", result_o.r11, want.r11);
        if (result_o.r12 !== want.r12) report_mismatch("r12", result_o.r12, want.r12);
        if (result_o.r20 !== want.r20) report_mismatch("r20", result_o.r20, want.r20);
        if (result_o.r21 !== want.r21) report_mismatch("r21", result_o.r21, want.r21);
        if (result_o.r22 !== want.r22) report_mismatch("r22", result_o.r22, want.r22);
        if (result_o.degenerate !== want.degenerate)
          report_mismatch("degenerate", result_o.degenerate, want.degenerate);
        if (want.degenerate) degen_count++;
      end
      result_count++;
    end
  end

  function automatic quat_t make_quat(input int x, input int y, input int z, input int w);
    quat_t q;
    q.quat_x = WORD_W'(x);
    q.quat_y = WORD_W'(y);
    q.quat_z = WORD_W'(z);
    q.quat_w = WORD_W'(w);
    return q;
  endfunction

  function automatic logic [WORD_W-1:0] rand_component(input int kind);
    case (kind)
      0: return WORD_W'($urandom_range(0, 3) - 2);
      1: return $urandom_range(0, 1) ? SMAX : SMIN;
      2: return WORD_W'($urandom_range(0, 255) - 128);
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_quat(make_quat(0, 0, 0, 0), 1'b0);
    send_quat(make_quat(0, 0, 0, 16384), 1'b0);
    send_quat(make_quat(0, 0, 0, -32768), 1'b0);
    send_quat(make_quat(32767, 0, 0, 0), 1'b0);
    send_quat(make_quat(0, -32768, 0, 0), 1'b0);
    send_quat(make_quat(0, 0, 32767, 0), 1'b0);
    send_quat(make_quat(32767, 32767, 32767, 32767), 1'b0);
    send_quat(make_quat(-32768, -32768, -32768, -32768), 1'b0);
    send_quat(make_quat(-32768, 32767, -32768, 32767), 1'b0);
    send_quat(make_quat(1, 0, 0, 0), 1'b0);
    send_quat(make_quat(0, 0, 0, -1), 1'b0);
    send_quat(make_quat(1, 1, 1, 1), 1'b0);
    send_quat(make_quat(2, 4, -6, 8), 1'b0);
    send_quat(make_quat(1, 2, 0, 0), 1'b0);
    send_quat(make_quat(11585, 0, 0, 11585), 1'b0);
    send_quat(make_quat(-1, -1, -1, -1), 1'b0);
    send_quat(make_quat(3, -5, 7, -9), 1'b0);
    send_quat(make_quat(0, 0, 0, 0), 1'b0);
  endtask

  task automatic test_random(input int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_quat(make_quat(0, 0, 0, 0), 1'b1);
      end else begin
        send_quat(make_quat(rand_component(kind % 4), rand_component($urandom_range(0, 3)),
                            rand_component($urandom_range(0, 3)),
                            rand_component($urandom_range(0, 3))), i % 200 < 150);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    quat_i      = '0;
    error_count = 0;
    beat_count  = 0;
    result_count = 0;
    degen_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1830);
    start_i <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d quaternion beats, checked %0d matrix beats, %0d of them degenerate.",
             beat_count, result_count, degen_count);
    if (error_count == 0 && matrix_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d matrix beats still outstanding.", matrix_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
